// File: design/gbd_pkg.sv
// Shared types, class codes and rule helpers for the grapheme boundary detector.
`default_nettype none
package gbd_pkg;

    localparam logic [3:0] CLS_OTHER       = 4'd0;
    localparam logic [3:0] CLS_CR          = 4'd1;
    localparam logic [3:0] CLS_LF          = 4'd2;
    localparam logic [3:0] CLS_CONTROL     = 4'd3;
    localparam logic [3:0] CLS_EXTEND      = 4'd4;
    localparam logic [3:0] CLS_ZWJ         = 4'd5;
    localparam logic [3:0] CLS_RI          = 4'd6;
    localparam logic [3:0] CLS_PREPEND     = 4'd7;
    localparam logic [3:0] CLS_SPACINGMARK = 4'd8;
    localparam logic [3:0] CLS_L           = 4'd9;
    localparam logic [3:0] CLS_V           = 4'd10;
    localparam logic [3:0] CLS_T           = 4'd11;
    localparam logic [3:0] CLS_LV          = 4'd12;
    localparam logic [3:0] CLS_LVT         = 4'd13;

    localparam logic [1:0] ICB_NONE      = 2'd0;
    localparam logic [1:0] ICB_LINKER    = 2'd1;
    localparam logic [1:0] ICB_CONSONANT = 2'd2;
    localparam logic [1:0] ICB_EXTEND    = 2'd3;

    localparam logic [1:0] EMO_IDLE = 2'd0;
    localparam logic [1:0] EMO_PICT = 2'd1;
    localparam logic [1:0] EMO_ZWJ  = 2'd2;

    localparam logic [1:0] CNJ_IDLE = 2'd0;
    localparam logic [1:0] CNJ_CONS = 2'd1;
    localparam logic [1:0] CNJ_LINK = 2'd2;

    typedef struct packed {
        logic [3:0] cls;
        logic [1:0] icb;
        logic       pict;
        logic       start;
        logic       is_ctrl;
        logic       absorbs;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_ctrl(input logic [3:0] c);
        return (c == CLS_CR) || (c == CLS_LF) || (c == CLS_CONTROL);
    endfunction

    function automatic logic hangul_join(input logic [3:0] a, input logic [3:0] b);
        logic join_ok;
        join_ok = 1'b0;
        if (a == CLS_L) begin
            join_ok = (b == CLS_L) || (b == CLS_V) || (b == CLS_LV) || (b == CLS_LVT);
        end else if ((a == CLS_V) || (a == CLS_LV)) begin
            join_ok = (b == CLS_V) || (b == CLS_T);
        end else if ((a == CLS_LVT) || (a == CLS_T)) begin
            join_ok = (b == CLS_T);
        end
        return join_ok;
    endfunction

endpackage
`default_nettype wire

// File: design/gbd_front.sv
// Front stage: accept items, classify them and register them toward the queue.
`default_nettype none
module gbd_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [3:0]        i_break_class,
    input  wire  [1:0]        i_conjunct_class,
    input  wire               i_pictographic,
    input  wire               i_text_start,
    output logic              o_push,
    output gbd_pkg::t_item    o_item,
    input  wire  gbd_pkg::t_q_status i_q_status
);
    import gbd_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.cls     = i_break_class;
        n_item.icb     = i_conjunct_class;
        n_item.pict    = i_pictographic;
        n_item.start   = i_text_start;
        n_item.is_ctrl = is_ctrl(i_break_class);
        n_item.absorbs = (i_break_class == CLS_EXTEND) || (i_break_class == CLS_ZWJ) ||
                         (i_break_class == CLS_SPACINGMARK);
    end

    assign o_push  = r_valid && !i_q_status.full;
    assign o_ready = !r_valid || !i_q_status.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// File: design/gbd_queue.sv
// Short queue of classified items between the front and back stages.
`default_nettype none
module gbd_queue #(
    parameter int DEPTH = 2
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire  gbd_pkg::t_item i_item,
    input  wire                i_pop,
    output gbd_pkg::t_item     o_item,
    output gbd_pkg::t_q_status o_status
);
    import gbd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// File: design/gbd_back.sv
// Back stage: apply the boundary rules, update trackers, register the result.
`default_nettype none
module gbd_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  gbd_pkg::t_item i_item,
    input  wire  gbd_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  wire                i_ready,
    output logic               o_boundary_before
);
    import gbd_pkg::*;

    logic [3:0] r_prev_class;
    logic       r_parity;
    logic [1:0] r_emo;
    logic [1:0] r_cnj;
    logic       r_out_valid;
    logic       r_boundary;

    logic       pair_brk;
    logic       brk;
    logic       par_eff;
    logic [1:0] emo_eff;
    logic [1:0] cnj_eff;
    logic       n_parity;
    logic [1:0] n_emo;
    logic [1:0] n_cnj;

    assign o_pop             = !i_q_status.empty && (!r_out_valid || i_ready);
    assign o_valid           = r_out_valid;
    assign o_boundary_before = r_boundary;

    always_comb begin
        if ((r_prev_class == CLS_CR) && (i_item.cls == CLS_LF)) begin
            pair_brk = 1'b0;
        end else if (is_ctrl(r_prev_class) || i_item.is_ctrl) begin
            pair_brk = 1'b1;
        end else if (hangul_join(r_prev_class, i_item.cls)) begin
            pair_brk = 1'b0;
        end else if (i_item.absorbs || (r_prev_class == CLS_PREPEND)) begin
            pair_brk = 1'b0;
        end else begin
            pair_brk = 1'b1;
        end

        if (i_item.start) begin
            brk = 1'b1;
        end else if (!pair_brk) begin
            brk = 1'b0;
        end else if ((i_item.icb == ICB_CONSONANT) && (r_cnj == CNJ_LINK)) begin
            brk = 1'b0;
        end else if (i_item.pict && (r_emo == EMO_ZWJ)) begin
            brk = 1'b0;
        end else if ((r_prev_class == CLS_RI) && (i_item.cls == CLS_RI) && r_parity) begin
            brk = 1'b0;
        end else begin
            brk = 1'b1;
        end

        par_eff = brk ? 1'b0 : r_parity;
        emo_eff = brk ? EMO_IDLE : r_emo;
        cnj_eff = brk ? CNJ_IDLE : r_cnj;

        n_parity = (i_item.cls == CLS_RI) ? !par_eff : 1'b0;

        n_emo = EMO_IDLE;
        if (i_item.cls == CLS_EXTEND) begin
            n_emo = (emo_eff == EMO_ZWJ) ? EMO_IDLE : emo_eff;
        end
        if (i_item.cls == CLS_ZWJ) begin
            n_emo = (emo_eff == EMO_PICT) ? EMO_ZWJ : EMO_IDLE;
        end
        if (i_item.pict) begin
            n_emo = EMO_PICT;
        end

        case (i_item.icb)
            ICB_CONSONANT: n_cnj = CNJ_CONS;
            ICB_EXTEND:    n_cnj = cnj_eff;
            ICB_LINKER:    n_cnj = (cnj_eff != CNJ_IDLE) ? CNJ_LINK : CNJ_IDLE;
            default:       n_cnj = CNJ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_class <= CLS_OTHER;
            r_parity     <= 1'b0;
            r_emo        <= EMO_IDLE;
            r_cnj        <= CNJ_IDLE;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_prev_class <= i_item.cls;
                r_parity     <= n_parity;
                r_emo        <= n_emo;
                r_cnj        <= n_cnj;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
        if (o_pop) begin
            r_boundary <= brk;
        end
    end

endmodule
`default_nettype wire

// File: design/grapheme_boundary_detector.sv
// Top level of the grapheme cluster boundary detector.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_ready  i_break_class, i_conjunct_class,
//                                           i_pictographic, i_text_start
//   result    out        o_valid / i_ready  o_boundary_before
//
// One item per cycle sustained while i_ready is high, set by the back-stage state loop.
// After the accepting edge an item passes the queue write, then the result register, before o_valid rises.
// Synchronous active-low reset clears the trackers, queue and valid flags.
// A stall on i_ready holds one item in the result register, QUEUE_DEPTH in the queue
// and one in the front register; then o_ready drops.
`default_nettype none
module grapheme_boundary_detector #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [3:0] i_break_class,
    input  wire  [1:0] i_conjunct_class,
    input  wire        i_pictographic,
    input  wire        i_text_start,
    output logic       o_valid,
    input  wire        i_ready,
    output logic       o_boundary_before
);
    import gbd_pkg::*;

    logic      push;
    logic      pop;
    t_item     front_item;
    t_item     queue_item;
    t_q_status q_status;

    gbd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_break_class    (i_break_class),
        .i_conjunct_class (i_conjunct_class),
        .i_pictographic   (i_pictographic),
        .i_text_start     (i_text_start),
        .o_push           (push),
        .o_item           (front_item),
        .i_q_status       (q_status)
    );

    gbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    gbd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (queue_item),
        .i_q_status        (q_status),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_boundary_before (o_boundary_before)
    );

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !pop)
        else $error("pop from empty queue");

    a_start_breaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && queue_item.start) |=> (o_valid && o_boundary_before))
        else $error("text start item without boundary");

endmodule
`default_nettype wire
